// File: rtl/core/sequence_reorder_store_unit_assert.svh
// Assertion macros used by the checker file.
`ifndef SEQUENCE_REORDER_STORE_UNIT_ASSERT_SVH
`define SEQUENCE_REORDER_STORE_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define SRU_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: label");

// Next-cycle implication, sampled on clk, off while in reset.
`define SRU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: label");

`endif

// File: rtl/core/sru_pkg.sv
`default_nettype none
package sru_pkg;

    localparam int SLOTS_DEF     = 64;
    localparam int MSG_BYTES_DEF = 256;

    // status codes
    localparam logic [3:0] ST_OK           = 4'd0;
    localparam logic [3:0] ST_NOT_INIT     = 4'd1;
    localparam logic [3:0] ST_EMPTY        = 4'd2;
    localparam logic [3:0] ST_TOO_LARGE    = 4'd3;
    localparam logic [3:0] ST_INVARIANT    = 4'd4;
    localparam logic [3:0] ST_DUP_MISMATCH = 4'd5;
    localparam logic [3:0] ST_DUP_EQUAL    = 4'd6;
    localparam logic [3:0] ST_COUNT_FULL   = 4'd7;
    localparam logic [3:0] ST_BYTES_FULL   = 4'd8;
    localparam logic [3:0] ST_INFO         = 4'd9;

    // item kinds
    localparam logic [1:0] KIND_INSERT   = 2'd0;
    localparam logic [1:0] KIND_RELEASE  = 2'd1;
    localparam logic [1:0] KIND_QUERY    = 2'd2;
    localparam logic [1:0] KIND_RESERVED = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_ENABLED      = 2'd0;
    localparam logic [1:0] CFG_MAX_MESSAGES = 2'd1;
    localparam logic [1:0] CFG_MAX_BYTES    = 2'd2;
    localparam logic [1:0] CFG_MAX_MSG_LEN  = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] seq_num;
        logic        feed_side;
        logic [63:0] capture_pos;
        logic [63:0] capture_time_ns;
        logic [15:0] body_length;
        logic [7:0]  body_byte;
        logic        last;
    } item_t;

    typedef struct packed {
        logic [3:0]  status;
        logic        slot_occupied;
        logic [31:0] slot_seq;
        logic        slot_side;
        logic [63:0] slot_capture_index;
        logic [63:0] slot_capture_ns;
        logic [8:0]  slot_length;
        logic [6:0]  held_messages;
        logic [14:0] held_bytes;
    } result_t;

    // per-slot metadata entry
    typedef struct packed {
        logic [31:0] seq;
        logic        side;
        logic [63:0] cap_idx;
        logic [63:0] cap_ns;
        logic [8:0]  len;
    } meta_t;

    // metadata store control
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clr_valid;
        logic clr_all;
    } meta_ctrl_t;

endpackage
`default_nettype wire

// File: rtl/core/sru_meta_store.sv
`default_nettype none
module sru_meta_store #(
    parameter int SLOTS = sru_pkg::SLOTS_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire sru_pkg::meta_ctrl_t      ctrl,
    input  wire logic [$clog2(SLOTS)-1:0] rd_addr,
    input  wire logic [$clog2(SLOTS)-1:0] wr_addr,
    input  wire sru_pkg::meta_t           wr_data,
    output sru_pkg::meta_t                rd_data,
    output logic                          rd_occ
);
    sru_pkg::meta_t mem [SLOTS];
    logic [SLOTS-1:0] valid_reg;
    sru_pkg::meta_t rd_data_reg;
    logic rd_occ_reg;

    // metadata array, registered read
    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctrl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // occupancy bits; a clear slot reads back with rd_occ low
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_occ_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.clr_all)
            begin
                valid_reg <= '0;
            end
            else if (ctrl.wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            else if (ctrl.clr_valid)
            begin
                valid_reg[wr_addr] <= 1'b0;
            end
            if (ctrl.rd_en)
            begin
                rd_occ_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;
    assign rd_occ  = rd_occ_reg;
endmodule
`default_nettype wire

// File: rtl/core/sru_payload_mem.sv
`default_nettype none
module sru_payload_mem #(
    parameter int DEPTH = sru_pkg::SLOTS_DEF * sru_pkg::MSG_BYTES_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [7:0]               wr_data,
    output logic [7:0]                    rd_data
);
    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    // byte RAM, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule
`default_nettype wire

// File: rtl/core/sequence_reorder_store_unit.sv
// Sequence reorder store: messages kept in slots chosen by seq_num modulo SLOTS.
// Command channel: an item transfers when start is high and busy is low.
// Inserts come as runs of byte items; the last byte returns one status.
// Release frees a slot if enabled, no result; query returns slot metadata.
// Result channel: done strobes for one cycle with result; no back-pressure.
// Latency: the result appears in the cycle after the item's transfer.
// One item at a time: busy blocks transfers while one executes; the metadata and
// payload memories are read in the transfer cycle, written back in the next one.
// Configuration: cfg_valid/cfg_ready write channel, cfg_ready always high;
// the user must make writes only while no item is in flight; the block
// has no check for it. Changing enabled empties all slots and zeroes the totals.
// Reset: all slots empty, totals zero, disabled, limits 64 msgs, 16384 B, 256 B.
// Payload RAM is not cleared; read data is used only by duplicate compares.
// SLOTS and MSG_BYTES must be powers of two; nothing in the block checks it.
`default_nettype none
module sequence_reorder_store_unit #(
    parameter int SLOTS     = sru_pkg::SLOTS_DEF,
    parameter int MSG_BYTES = sru_pkg::MSG_BYTES_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire sru_pkg::item_t item,
    output logic                done,
    output sru_pkg::result_t    result,
    input  wire logic           cfg_valid,
    output logic                cfg_ready,
    input  wire logic [1:0]     cfg_index,
    input  wire logic [15:0]    cfg_data
);
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int PAY_W  = $clog2(SLOTS * MSG_BYTES);
    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg, state_next;
    sru_pkg::item_t item_reg;
    logic        enabled_reg;
    logic [6:0]  max_msgs_reg;
    logic [14:0] max_bytes_reg;
    logic [8:0]  max_len_reg;
    logic [15:0] pos_reg, pos_next;
    logic [3:0]  verdict_reg, verdict_next;
    logic        wn_reg, wn_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [14:0] tot_reg, tot_next;

    logic accept, exec, en_change;
    logic [SLOT_W-1:0] slot_in, slot_x;
    logic [PAY_W-1:0]  pay_rd_addr, pay_wr_addr;
    logic [7:0] pay_rd_data;
    logic pay_wr_en;
    sru_pkg::meta_ctrl_t meta_ctrl;
    sru_pkg::meta_t meta_rd, meta_wr;
    logic meta_occ;

    logic [15:0] len, limit, store_len;
    logic [16:0] sum;
    logic [3:0]  first_v, v0;
    logic        wn0, in_range;

    assign accept    = start && !busy;
    assign busy      = (state_reg == S_EXEC);
    assign exec      = (state_reg == S_EXEC);
    assign cfg_ready = 1'b1;
    assign en_change = cfg_valid && (cfg_index == sru_pkg::CFG_ENABLED)
                       && (cfg_data[0] != enabled_reg);

    assign slot_in     = item.seq_num[SLOT_W-1:0];
    assign slot_x      = item_reg.seq_num[SLOT_W-1:0];
    assign pay_rd_addr = PAY_W'(slot_in) * PAY_W'(MSG_BYTES) + PAY_W'(pos_reg);
    assign pay_wr_addr = PAY_W'(slot_x) * PAY_W'(MSG_BYTES) + PAY_W'(pos_reg);

    sru_meta_store #(.SLOTS(SLOTS)) u_meta (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (meta_ctrl),
        .rd_addr (slot_in),
        .wr_addr (slot_x),
        .wr_data (meta_wr),
        .rd_data (meta_rd),
        .rd_occ  (meta_occ)
    );

    sru_payload_mem #(.DEPTH(SLOTS * MSG_BYTES)) u_payload (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (pay_rd_addr),
        .wr_en   (pay_wr_en),
        .wr_addr (pay_wr_addr),
        .wr_data (item_reg.body_byte),
        .rd_data (pay_rd_data)
    );

    // verdict at the first byte of a run
    always_comb
    begin
        len   = item_reg.body_length;
        limit = (16'(max_len_reg) > 16'(MSG_BYTES)) ? 16'(MSG_BYTES) : 16'(max_len_reg);
        sum   = 17'(tot_reg) + 17'(len);
        if (!enabled_reg)
            first_v = sru_pkg::ST_NOT_INIT;
        else if (len == 16'd0)
            first_v = sru_pkg::ST_EMPTY;
        else if (len > limit)
            first_v = sru_pkg::ST_TOO_LARGE;
        else if (meta_occ && (meta_rd.seq != item_reg.seq_num))
            first_v = sru_pkg::ST_INVARIANT;
        else if (meta_occ && (16'(meta_rd.len) != len))
            first_v = sru_pkg::ST_DUP_MISMATCH;
        else if (meta_occ)
            first_v = sru_pkg::ST_DUP_EQUAL;
        else if (cnt_reg >= max_msgs_reg)
            first_v = sru_pkg::ST_COUNT_FULL;
        else if (sum > 17'(max_bytes_reg))
            first_v = sru_pkg::ST_BYTES_FULL;
        else
            first_v = sru_pkg::ST_OK;
        v0  = (pos_reg == 16'd0) ? first_v : verdict_reg;
        wn0 = (pos_reg == 16'd0) ? (first_v == sru_pkg::ST_OK) : wn_reg;
        in_range  = (pos_reg < len) && (pos_reg < 16'(MSG_BYTES));
        store_len = (len > 16'(MSG_BYTES)) ? 16'(MSG_BYTES) : len;
    end

    // execute cycle: byte write or compare, commit, release, query; enable change clears all
    always_comb
    begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        verdict_next = verdict_reg;
        wn_next      = wn_reg;
        cnt_next     = cnt_reg;
        tot_next     = tot_reg;
        pay_wr_en    = 1'b0;
        meta_ctrl    = '0;
        meta_ctrl.rd_en = accept;
        meta_wr.seq     = item_reg.seq_num;
        meta_wr.side    = item_reg.feed_side;
        meta_wr.cap_idx = item_reg.capture_pos;
        meta_wr.cap_ns  = item_reg.capture_time_ns;
        meta_wr.len     = store_len[8:0];
        done   = 1'b0;
        result = '0;

        if (accept)
            state_next = S_EXEC;
        if (exec)
        begin
            state_next = S_IDLE;
            case (item_reg.kind)
                sru_pkg::KIND_INSERT:
                begin
                    verdict_next = v0;
                    wn_next      = wn0;
                    if (in_range && wn0)
                        pay_wr_en = 1'b1;
                    else if (in_range && (v0 == sru_pkg::ST_DUP_EQUAL)
                             && (pay_rd_data != item_reg.body_byte))
                        verdict_next = sru_pkg::ST_DUP_MISMATCH;
                    pos_next = (pos_reg != 16'hFFFF) ? pos_reg + 16'd1 : pos_reg;
                    if (item_reg.last)
                    begin
                        if (wn0)
                        begin
                            meta_ctrl.wr_en = 1'b1;
                            cnt_next = cnt_reg + 7'd1;
                            tot_next = tot_reg + store_len[14:0];
                        end
                        done = 1'b1;
                        result.status        = verdict_next;
                        result.held_messages = cnt_next;
                        result.held_bytes    = tot_next;
                        pos_next     = '0;
                        verdict_next = '0;
                        wn_next      = 1'b0;
                    end
                end
                sru_pkg::KIND_RELEASE:
                begin
                    pos_next     = '0;
                    verdict_next = '0;
                    wn_next      = 1'b0;
                    if (enabled_reg)
                    begin
                        meta_ctrl.clr_valid = 1'b1;
                        if (meta_occ)
                        begin
                            cnt_next = cnt_reg - 7'd1;
                            tot_next = tot_reg - 15'(meta_rd.len);
                        end
                    end
                end
                sru_pkg::KIND_QUERY:
                begin
                    pos_next     = '0;
                    verdict_next = '0;
                    wn_next      = 1'b0;
                    done = 1'b1;
                    result.status        = sru_pkg::ST_INFO;
                    result.held_messages = cnt_reg;
                    result.held_bytes    = tot_reg;
                    if (meta_occ)
                    begin
                        result.slot_occupied      = 1'b1;
                        result.slot_seq           = meta_rd.seq;
                        result.slot_side          = meta_rd.side;
                        result.slot_capture_index = meta_rd.cap_idx;
                        result.slot_capture_ns    = meta_rd.cap_ns;
                        result.slot_length        = meta_rd.len;
                    end
                end
                default:
                begin
                    // unknown kind: run state kept
                end
            endcase
        end
        if (en_change)
        begin
            meta_ctrl.clr_all = 1'b1;
            pos_next     = '0;
            verdict_next = '0;
            wn_next      = 1'b0;
            cnt_next     = '0;
            tot_next     = '0;
        end
    end

    // item capture
    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= item;
    end

    // control and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= '0;
            verdict_reg   <= '0;
            wn_reg        <= 1'b0;
            cnt_reg       <= '0;
            tot_reg       <= '0;
            enabled_reg   <= 1'b0;
            max_msgs_reg  <= 7'd64;
            max_bytes_reg <= 15'd16384;
            max_len_reg   <= 9'd256;
        end
        else
        begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            verdict_reg <= verdict_next;
            wn_reg      <= wn_next;
            cnt_reg     <= cnt_next;
            tot_reg     <= tot_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    sru_pkg::CFG_ENABLED:      enabled_reg   <= cfg_data[0];
                    sru_pkg::CFG_MAX_MESSAGES: max_msgs_reg  <= cfg_data[6:0];
                    sru_pkg::CFG_MAX_BYTES:    max_bytes_reg <= cfg_data[14:0];
                    sru_pkg::CFG_MAX_MSG_LEN:  max_len_reg   <= cfg_data[8:0];
                    default:                   max_len_reg   <= max_len_reg;
                endcase
            end
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/sru_checker.sv
`default_nettype none
`include "sequence_reorder_store_unit_assert.svh"
module sru_checker (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             start,
    input wire logic             busy,
    input wire logic             done,
    input wire sru_pkg::result_t result
);
    // a transfer occupies the block for the next cycle
    `SRU_ASSERT_NEXT(a_busy_after_transfer, start && !busy, busy)
    // results only while an item is in flight
    `SRU_ASSERT_IMPL(a_done_while_busy, done, busy)
    // every result follows a transfer in the previous cycle
    `SRU_ASSERT_IMPL(a_done_after_transfer, done, $past(start && !busy))
    // a committed insert leaves at least one message held
    `SRU_ASSERT_IMPL(a_ok_holds_message, done && (result.status == sru_pkg::ST_OK),
        result.held_messages != 7'd0)
endmodule

bind sequence_reorder_store_unit sru_checker u_sru_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
`default_nettype wire

// File: tb/sequence_reorder_store_unit_tb.sv
`timescale 1ns / 1ps
`default_nettype none
module sequence_reorder_store_unit_tb;

    localparam int NSLOT = sru_pkg::SLOTS_DEF;
    localparam int NBYTE = sru_pkg::MSG_BYTES_DEF;
    localparam int CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    sru_pkg::item_t item;
    logic done;
    sru_pkg::result_t result;
    logic cfg_valid;
    logic cfg_ready;
    logic [1:0] cfg_index;
    logic [15:0] cfg_data;

    sequence_reorder_store_unit dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor state
    logic        en_r;
    logic [6:0]  max_msgs_r;
    logic [14:0] max_bytes_r;
    logic [8:0]  max_len_r;
    logic        occ_m [NSLOT];
    logic [31:0] seq_m [NSLOT];
    logic        side_m [NSLOT];
    logic [63:0] cidx_m [NSLOT];
    logic [63:0] cns_m [NSLOT];
    logic [8:0]  len_m [NSLOT];
    logic [7:0]  payload_m [NSLOT*NBYTE];
    logic [6:0]  msg_count;
    logic [14:0] byte_count;
    logic [15:0] run_pos;
    logic [3:0]  run_verdict;
    logic        run_new;

    sru_pkg::item_t   pending_items[$];
    sru_pkg::result_t expected_results[$];
    int      errors;
    int      cycles;
    logic    driver_on;
    logic    quiet;
    logic    accepted_last;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void clear_slots();
        for (int i = 0; i < NSLOT; i++)
        begin
            occ_m[i] = 1'b0;
            seq_m[i] = '0;
            side_m[i] = 1'b0;
            cidx_m[i] = '0;
            cns_m[i] = '0;
            len_m[i] = '0;
        end
        msg_count = '0;
        byte_count = '0;
        run_pos = '0;
        run_verdict = sru_pkg::ST_OK;
        run_new = 1'b0;
    endfunction

    function automatic logic [3:0] first_check(int s, logic [31:0] sq, logic [15:0] ln);
        int lim;
        lim = (max_len_r > NBYTE) ? NBYTE : max_len_r;
        if (!en_r) return sru_pkg::ST_NOT_INIT;
        if (ln == 0) return sru_pkg::ST_EMPTY;
        if (ln > lim) return sru_pkg::ST_TOO_LARGE;
        if (occ_m[s])
        begin
            if (seq_m[s] != sq) return sru_pkg::ST_INVARIANT;
            if (len_m[s] != ln) return sru_pkg::ST_DUP_MISMATCH;
            return sru_pkg::ST_DUP_EQUAL;
        end
        if (msg_count >= max_msgs_r) return sru_pkg::ST_COUNT_FULL;
        if (32'(byte_count) + 32'(ln) > 32'(max_bytes_r)) return sru_pkg::ST_BYTES_FULL;
        return sru_pkg::ST_OK;
    endfunction

    // advance the store model by one accepted item
    function automatic void store_step(sru_pkg::item_t it);
        int s;
        int sl;
        sru_pkg::result_t r;
        s = it.seq_num % NSLOT;
        r = '0;
        if (it.kind == sru_pkg::KIND_INSERT)
        begin
            if (run_pos == 0)
            begin
                run_verdict = first_check(s, it.seq_num, it.body_length);
                run_new = (run_verdict == sru_pkg::ST_OK);
            end
            if (run_pos < it.body_length && run_pos < NBYTE)
            begin
                if (run_new)
                    payload_m[s*NBYTE + run_pos] = it.body_byte;
                else if (run_verdict == sru_pkg::ST_DUP_EQUAL &&
                         payload_m[s*NBYTE + run_pos] != it.body_byte)
                    run_verdict = sru_pkg::ST_DUP_MISMATCH;
            end
            if (run_pos != 16'hFFFF) run_pos++;
            if (!it.last) return;
            if (run_new)
            begin
                sl = (it.body_length > NBYTE) ? NBYTE : it.body_length;
                occ_m[s] = 1'b1;
                seq_m[s] = it.seq_num;
                side_m[s] = it.feed_side;
                cidx_m[s] = it.capture_pos;
                cns_m[s] = it.capture_time_ns;
                len_m[s] = 9'(sl);
                msg_count = msg_count + 7'd1;
                byte_count = byte_count + 15'(sl);
            end
            r.status = run_verdict;
            r.held_messages = msg_count;
            r.held_bytes = byte_count;
            expected_results.push_back(r);
            run_pos = '0;
            run_verdict = sru_pkg::ST_OK;
            run_new = 1'b0;
            return;
        end
        if (it.kind == sru_pkg::KIND_RESERVED) return;
        run_pos = '0;
        run_verdict = sru_pkg::ST_OK;
        run_new = 1'b0;
        if (it.kind == sru_pkg::KIND_RELEASE)
        begin
            if (!en_r) return;
            if (occ_m[s])
            begin
                byte_count = byte_count - 15'(len_m[s]);
                msg_count = msg_count - 7'd1;
            end
            occ_m[s] = 1'b0;
            seq_m[s] = '0;
            side_m[s] = 1'b0;
            cidx_m[s] = '0;
            cns_m[s] = '0;
            len_m[s] = '0;
            return;
        end
        r.status = sru_pkg::ST_INFO;
        r.slot_occupied = occ_m[s];
        r.slot_seq = seq_m[s];
        r.slot_side = side_m[s];
        r.slot_capture_index = cidx_m[s];
        r.slot_capture_ns = cns_m[s];
        r.slot_length = len_m[s];
        r.held_messages = msg_count;
        r.held_bytes = byte_count;
        expected_results.push_back(r);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic sru_pkg::item_t make_item(logic [1:0] k, logic [31:0] sq,
                                                 logic [15:0] ln, logic [7:0] b,
                                                 logic lst);
        sru_pkg::item_t it;
        it.kind = k;
        it.seq_num = sq;
        it.feed_side = 1'($urandom_range(0, 1));
        it.capture_pos = rand64();
        it.capture_time_ns = rand64();
        it.body_length = ln;
        it.body_byte = b;
        it.last = lst;
        return it;
    endfunction

    // whole insert run; payload bytes follow a seed so duplicates can repeat them
    task automatic queue_insert(logic [31:0] sq, logic [15:0] ln, int nb, int seed);
        sru_pkg::item_t it;
        logic [63:0] ci;
        logic [63:0] cn;
        logic sd;
        ci = rand64();
        cn = rand64();
        sd = 1'($urandom_range(0, 1));
        for (int i = 0; i < nb; i++)
        begin
            it = make_item(sru_pkg::KIND_INSERT, sq, ln,
                           8'((seed * 37 + i * 11) ^ (i >> 3)), i == nb - 1);
            it.capture_pos = ci;
            it.capture_time_ns = cn;
            it.feed_side = sd;
            pending_items.push_back(it);
        end
    endtask

    task automatic drain();
        while (pending_items.size() != 0 || expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            sru_pkg::CFG_ENABLED:
            begin
                if (val[0] != en_r) clear_slots();
                en_r = val[0];
            end
            sru_pkg::CFG_MAX_MESSAGES: max_msgs_r = val[6:0];
            sru_pkg::CFG_MAX_BYTES:    max_bytes_r = val[14:0];
            default:                   max_len_r = val[8:0];
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // driver: one item offered at a time, idles at random unless quiet
    always @(negedge clk)
    begin
        if (rst_n && driver_on)
        begin
            if (!start || accepted_last)
            begin
                if (pending_items.size() != 0 && (quiet || $urandom_range(0, 99) >= 20))
                begin
                    item <= pending_items.pop_front();
                    start <= 1'b1;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // handshake seen at the rising edge
    always @(posedge clk)
    begin
        accepted_last = 1'b0;
        if (rst_n && start && !busy)
        begin
            accepted_last = 1'b1;
            store_step(item);
        end
    end

    // monitor: compare each result strobe with the oldest expectation
    always @(posedge clk)
    begin
        sru_pkg::result_t e;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, result);
                errors++;
            end
            else
            begin
                e = expected_results.pop_front();
                if (result.status !== e.status ||
                    result.slot_occupied !== e.slot_occupied ||
                    result.slot_seq !== e.slot_seq ||
                    result.slot_side !== e.slot_side ||
                    result.slot_capture_index !== e.slot_capture_index ||
                    result.slot_capture_ns !== e.slot_capture_ns ||
                    result.slot_length !== e.slot_length ||
                    result.held_messages !== e.held_messages ||
                    result.held_bytes !== e.held_bytes)
                begin
                    $display("%0t: mismatch expected %h actual %h", $time, e, result);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // random workload on a handful of sequence numbers so slots collide
    task automatic random_phase(int n_items);
        int made;
        int pick;
        int ln;
        int nb;
        logic [31:0] sq;
        made = 0;
        while (made < n_items)
        begin
            quiet = (made > n_items / 3 && made < n_items / 2);
            sq = ($urandom_range(0, 3) == 0) ? $urandom() : 32'($urandom_range(0, 11)) +
                 (($urandom_range(0, 3) == 0) ? 32'd64 : 32'd0);
            pick = $urandom_range(0, 99);
            if (pick < 60)
            begin
                ln = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 300) :
                     $urandom_range(1, 12);
                if ($urandom_range(0, 19) == 0) ln = $urandom_range(0, 65535);
                nb = ln > 16 ? $urandom_range(1, 16) : (ln == 0 ? 1 : ln);
                // short runs never land where a later duplicate compare could read them
                if (nb < ln && ln <= NBYTE) nb = ln > 16 ? 16 : ln;
                if (nb < ln && ln <= NBYTE && ln > 16) ln = $urandom_range(300, 65535);
                queue_insert(sq, 16'(ln), nb,
                             int'(sq[3:0]) ^ int'($urandom_range(0, 7) == 0));
                made += nb;
            end
            else if (pick < 75)
            begin
                pending_items.push_back(make_item(sru_pkg::KIND_RELEASE, sq,
                                                  16'($urandom()), 8'($urandom()), 1'b1));
                made++;
            end
            else if (pick < 95)
            begin
                pending_items.push_back(make_item(sru_pkg::KIND_QUERY, sq,
                                                  16'($urandom()), 8'($urandom()),
                                                  1'($urandom_range(0, 1))));
                made++;
            end
            else
            begin
                // broken run: two bytes and a reserved item, then a query abandons it
                queue_insert(sq, 16'd8, 3, 1);
                void'(pending_items.pop_back());
                pending_items.push_back(make_item(sru_pkg::KIND_RESERVED, sq,
                                                  16'd0, 8'd0, 1'b1));
                pending_items.push_back(make_item(sru_pkg::KIND_QUERY, sq,
                                                  16'd0, 8'd0, 1'b1));
                made += 4;
            end
            while (pending_items.size() > 64) @(posedge clk);
        end
        quiet = 1'b0;
        drain();
    endtask

    initial
    begin
        errors = 0;
        cycles = 0;
        driver_on = 1'b0;
        quiet = 1'b0;
        accepted_last = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        cfg_valid = 1'b0;
        cfg_index = sru_pkg::CFG_ENABLED;
        cfg_data = '0;
        en_r = 1'b0;
        max_msgs_r = 7'd64;
        max_bytes_r = 15'd16384;
        max_len_r = 9'd256;
        for (int i = 0; i < NSLOT*NBYTE; i++) payload_m[i] = '0;
        clear_slots();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        driver_on = 1'b1;

        // directed: disabled store, then enable; all verdicts but the full ones
        queue_insert(32'd5, 16'd2, 2, 0);
        pending_items.push_back(make_item(sru_pkg::KIND_RELEASE, 32'd5, 16'd0, 8'd0, 1'b1));
        pending_items.push_back(make_item(sru_pkg::KIND_QUERY, 32'hFFFF_FFFF, 16'hFFFF,
                                          8'hFF, 1'b1));
        drain();
        write_reg(sru_pkg::CFG_ENABLED, 16'd1);
        queue_insert(32'd1, 16'd0, 1, 0);
        queue_insert(32'd1, 16'd257, 1, 0);
        queue_insert(32'd1, 16'hFFFF, 1, 0);
        queue_insert(32'hFFFF_FFC1, 16'd256, 256, 9);
        queue_insert(32'hFFFF_FFC1, 16'd256, 256, 9);
        queue_insert(32'd1, 16'd3, 1, 0);
        queue_insert(32'hFFFF_FFC1, 16'd4, 1, 0);
        queue_insert(32'd2, 16'd3, 3, 4);
        queue_insert(32'd2, 16'd3, 3, 5);
        pending_items.push_back(make_item(sru_pkg::KIND_RESERVED, 32'd2, 16'd0, 8'd0, 1'b1));
        pending_items.push_back(make_item(sru_pkg::KIND_QUERY, 32'd2, 16'd0, 8'd0, 1'b1));
        pending_items.push_back(make_item(sru_pkg::KIND_QUERY, 32'hFFFF_FFC1, 16'd0, 8'd0,
                                          1'b0));
        pending_items.push_back(make_item(sru_pkg::KIND_RELEASE, 32'd66, 16'd0, 8'd0, 1'b1));
        pending_items.push_back(make_item(sru_pkg::KIND_QUERY, 32'd2, 16'd0, 8'd0, 1'b1));
        drain();

        // tight limits
        write_reg(sru_pkg::CFG_MAX_MESSAGES, 16'd1);
        write_reg(sru_pkg::CFG_MAX_BYTES, 16'd260);
        write_reg(sru_pkg::CFG_MAX_MSG_LEN, 16'd0);
        queue_insert(32'd3, 16'd1, 1, 0);
        drain();
        write_reg(sru_pkg::CFG_MAX_MSG_LEN, 16'd511);
        queue_insert(32'd3, 16'd2, 2, 0);
        drain();
        write_reg(sru_pkg::CFG_MAX_MESSAGES, 16'd0);
        write_reg(sru_pkg::CFG_MAX_MESSAGES, 16'd2);
        queue_insert(32'd3, 16'd5, 5, 0);
        queue_insert(32'd4, 16'd5, 5, 0);
        drain();
        random_phase(100);

        // toggling enable empties all slots and zeroes the totals
        write_reg(sru_pkg::CFG_ENABLED, 16'd0);
        write_reg(sru_pkg::CFG_ENABLED, 16'd1);
        write_reg(sru_pkg::CFG_MAX_MESSAGES, 16'd64);
        write_reg(sru_pkg::CFG_MAX_BYTES, 16'd16384);
        write_reg(sru_pkg::CFG_MAX_MSG_LEN, 16'd256);
        random_phase(300);
        write_reg(sru_pkg::CFG_MAX_MESSAGES, 16'd127);
        write_reg(sru_pkg::CFG_MAX_BYTES, 16'd40);
        write_reg(sru_pkg::CFG_MAX_MSG_LEN, 16'd8);
        random_phase(200);
        write_reg(sru_pkg::CFG_MAX_BYTES, 16'h7FFF);
        write_reg(sru_pkg::CFG_MAX_MSG_LEN, 16'd1);
        random_phase(100);

        driver_on = 1'b0;
        repeat (10) @(posedge clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
`default_nettype wire

// File: files.f
+incdir+rtl/core
rtl/core/sru_pkg.sv
rtl/core/sru_meta_store.sv
rtl/core/sru_payload_mem.sv
rtl/core/sequence_reorder_store_unit.sv
rtl/core/sru_checker.sv
tb/sequence_reorder_store_unit_tb.sv
